// ===== design/led_pixel_dim_and_bit_encode_defines.svh =====
// Assertion macros shared by the LED pixel dimming and encoding design.
`ifndef LED_PIXEL_DIM_AND_BIT_ENCODE_DEFINES_SVH
`define LED_PIXEL_DIM_AND_BIT_ENCODE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lpd_pkg.sv =====
// Package with the shared types and constants of the LED pixel dimming and encoding design.
package lpd_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int CHAN_W         = 8;
    localparam int DUTY_W         = 7;
    localparam int PROD_W         = CHAN_W + DUTY_W;
    localparam int ADDR_W         = 15;
    localparam int CNT_W          = 5;
    localparam int COUNT_W        = 11;
    localparam int CFG_DATA_W     = 11;
    localparam int RECIP_W        = 13;
    localparam int RECIP_SHIFT    = 19;
    localparam int SCALED_W       = PROD_W + RECIP_W;

    localparam logic [DUTY_W-1:0]   FULL_DUTY  = DUTY_W'(100);
    localparam logic [RECIP_W-1:0]  RECIP_MULT = RECIP_W'(5243);
    localparam logic [CNT_W-1:0]    LAST_SLOT  = CNT_W'(BITS_PER_PIXEL - 1);
    localparam logic [COUNT_W-1:0]  PIXEL_COUNT_RESET = COUNT_W'(1024);

    typedef enum logic [1:0] {
        CFG_PIXEL_COUNT = 2'd0,
        CFG_PULSE_ONE   = 2'd1,
        CFG_PULSE_ZERO  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
    } lpd_adv_t;

endpackage

// ===== design/lpd_lane.sv =====
// One color lane that dims a channel byte to floor(channel * duty / 100) in two stages.
module lpd_lane
    import lpd_pkg::*;
(
    input  logic              clk,
    input  lpd_adv_t          adv,
    input  logic [CHAN_W-1:0] channel,
    input  logic [DUTY_W-1:0] duty,
    output logic [CHAN_W-1:0] level
);

    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [SCALED_W-1:0] scaled;
    logic [CHAN_W-1:0]   level_reg;
    logic [CHAN_W-1:0]   level_next;

    // The division by 100 is a multiplication by a rounded-up reciprocal.
    assign prod_next  = {{(PROD_W-CHAN_W){1'b0}}, channel} * {{(PROD_W-DUTY_W){1'b0}}, duty};
    assign scaled     = {{(SCALED_W-PROD_W){1'b0}}, prod_reg}
                        * {{(SCALED_W-RECIP_W){1'b0}}, RECIP_MULT};
    assign level_next = scaled[RECIP_SHIFT +: CHAN_W];

    always_ff @(posedge clk)
    begin
        if (adv.s1_load)
        begin
            prod_reg <= prod_next;
        end
        if (adv.s2_load)
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

// ===== design/lpd_serializer.sv =====
// Output stage that takes the three packed dimmed bytes and emits them as 24 pulse values.
`include "led_pixel_dim_and_bit_encode_defines.svh"

module lpd_serializer
    import lpd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [BITS_PER_PIXEL-1:0]   word,
    input  logic [ADDR_W-1:0]           base,
    input  logic [CHAN_W-1:0]           pulse_one,
    input  logic [CHAN_W-1:0]           pulse_zero,
    output logic                        can_load,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [CHAN_W-1:0]           pulse_value,
    output logic [ADDR_W-1:0]           slot_address,
    output logic                        last_bit
);

    logic                      busy_reg;
    logic                      busy_next;
    logic [BITS_PER_PIXEL-1:0] shift_reg;
    logic [BITS_PER_PIXEL-1:0] shift_next;
    logic [ADDR_W-1:0]         addr_reg;
    logic [ADDR_W-1:0]         addr_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic                      fire;
    logic                      at_last;

    assign fire     = busy_reg && out_ready;
    assign at_last  = (cnt_reg == LAST_SLOT);
    assign can_load = !busy_reg || (out_ready && at_last);

    always_comb
    begin
        busy_next  = busy_reg;
        shift_next = shift_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            shift_next = word;
            addr_next  = base;
            cnt_next   = '0;
        end
        else if (fire)
        begin
            shift_next = {shift_reg[BITS_PER_PIXEL-2:0], 1'b0};
            addr_next  = addr_reg + ADDR_W'(1);
            cnt_next   = cnt_reg + CNT_W'(1);
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        addr_reg  <= addr_next;
    end

    assign out_valid    = busy_reg;
    assign pulse_value  = shift_reg[BITS_PER_PIXEL-1] ? pulse_one : pulse_zero;
    assign slot_address = addr_reg;
    assign last_bit     = at_last;

    `LPD_ASSERT_SAME(a_load_when_free, load, !busy_reg || (out_ready && at_last), "load while busy")
    `LPD_ASSERT_NEXT(a_addr_steps, fire && !at_last && !load, addr_reg == $past(addr_reg) + ADDR_W'(1), "address did not advance")
    `LPD_ASSERT_NEXT(a_done_idle, fire && at_last && !load, !busy_reg, "busy after the last bit")
    `LPD_ASSERT_NEXT(a_load_starts, load, busy_reg && cnt_reg == '0, "load did not start a pixel")

endmodule

// ===== design/led_pixel_dim_and_bit_encode.sv =====
// A pixel passes the product and level registers before its first pulse value is offered.
// A pixel gives 24 pulse values, one per cycle from the shift register while out_ready is high.
// A new pixel is accepted while the previous one is still being shifted out.
// Pixels whose index is at or beyond the pixel count are accepted and give no pulse values.
// Reset clears the pipeline and sets pixel_count to 1024, pulse_one and pulse_zero to 0.
module led_pixel_dim_and_bit_encode
    import lpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [9:0]            pixel_index,
    input  logic [CHAN_W-1:0]     red,
    input  logic [CHAN_W-1:0]     green,
    input  logic [CHAN_W-1:0]     blue,
    input  logic [DUTY_W-1:0]     brightness,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHAN_W-1:0]     pulse_value,
    output logic [ADDR_W-1:0]     slot_address,
    output logic                  last_bit
);

    logic [COUNT_W-1:0] pixel_count_reg;
    logic [CHAN_W-1:0]  pulse_one_reg;
    logic [CHAN_W-1:0]  pulse_zero_reg;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic [ADDR_W-1:0]  s1_base_reg;
    logic [ADDR_W-1:0]  s1_base_next;
    logic [ADDR_W-1:0]  s2_base_reg;
    logic               in_fire;
    logic               in_range;
    logic               s2_ready;
    logic               ser_can_load;
    logic               ser_load;
    logic [DUTY_W-1:0]  duty;
    lpd_adv_t           adv;
    logic [CHAN_W-1:0]  red_level;
    logic [CHAN_W-1:0]  green_level;
    logic [CHAN_W-1:0]  blue_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= PIXEL_COUNT_RESET;
            pulse_one_reg   <= '0;
            pulse_zero_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PIXEL_COUNT: pixel_count_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_PULSE_ONE:   pulse_one_reg   <= cfg_wdata[CHAN_W-1:0];
                CFG_PULSE_ZERO:  pulse_zero_reg  <= cfg_wdata[CHAN_W-1:0];
                default:         ;
            endcase
        end
    end

    assign in_range = ({1'b0, pixel_index} < pixel_count_reg);
    assign duty     = (brightness > FULL_DUTY) ? FULL_DUTY : brightness;

    assign ser_load = s2_valid_reg && ser_can_load;
    assign s2_ready = !s2_valid_reg || ser_can_load;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign in_fire  = in_valid && in_ready;

    assign adv.s1_load = in_fire;
    assign adv.s2_load = s1_valid_reg && s2_ready;

    // Slot base is 24 times the index, built as 16x plus 8x.
    assign s1_base_next = {1'b0, pixel_index, 4'b0000} + {2'b00, pixel_index, 3'b000};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = in_range;
        end
        else if (adv.s2_load)
        begin
            s1_valid_next = 1'b0;
        end
        if (adv.s2_load)
        begin
            s2_valid_next = 1'b1;
        end
        else if (ser_load)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1_load)
        begin
            s1_base_reg <= s1_base_next;
        end
        if (adv.s2_load)
        begin
            s2_base_reg <= s1_base_reg;
        end
    end

    lpd_lane u_lane_red (
        .clk     (clk),
        .adv     (adv),
        .channel (red),
        .duty    (duty),
        .level   (red_level)
    );

    lpd_lane u_lane_green (
        .clk     (clk),
        .adv     (adv),
        .channel (green),
        .duty    (duty),
        .level   (green_level)
    );

    lpd_lane u_lane_blue (
        .clk     (clk),
        .adv     (adv),
        .channel (blue),
        .duty    (duty),
        .level   (blue_level)
    );

    lpd_serializer u_serializer (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (ser_load),
        .word         ({green_level, red_level, blue_level}),
        .base         (s2_base_reg),
        .pulse_one    (pulse_one_reg),
        .pulse_zero   (pulse_zero_reg),
        .can_load     (ser_can_load),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pulse_value  (pulse_value),
        .slot_address (slot_address),
        .last_bit     (last_bit)
    );

endmodule
